// ----- rtl/core/dnsp_pkg.sv -----
// Package for the DNS response A-record parser: payload structs, parser state,
// phase and status codes, header masks and message length limits.
// No dependencies.
package dnsp_pkg;

	localparam int MAX_MSG = 512;
	localparam int OFF_W   = $clog2(MAX_MSG + 1);

	localparam int HDR_LEN = 12;

	// parse phases
	localparam logic [3:0] PH_HDR      = 4'd0;
	localparam logic [3:0] PH_QLABEL   = 4'd1;
	localparam logic [3:0] PH_QLABSKIP = 4'd2;
	localparam logic [3:0] PH_QTAIL    = 4'd3;
	localparam logic [3:0] PH_ALABEL   = 4'd4;
	localparam logic [3:0] PH_ALABSKIP = 4'd5;
	localparam logic [3:0] PH_APTR     = 4'd6;
	localparam logic [3:0] PH_AFIXED   = 4'd7;
	localparam logic [3:0] PH_AADDR    = 4'd8;
	localparam logic [3:0] PH_ARDSKIP  = 4'd9;
	localparam logic [3:0] PH_DONE     = 4'd10;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_ID_MISM   = 3'd2;
	localparam logic [2:0] ST_NOT_RESP  = 3'd3;
	localparam logic [2:0] ST_RCODE     = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;
	localparam logic [2:0] ST_NO_A      = 3'd6;
	localparam logic [2:0] V_UNDECIDED  = 3'd7;

	localparam logic [15:0] HDR_QR_MASK    = 16'h8000;
	localparam logic [15:0] HDR_RCODE_MASK = 16'h000F;
	localparam logic [7:0]  PTR_MARK       = 8'hC0;

	// fixed part lengths
	localparam logic [15:0] QTAIL_LEN     = 16'd4;   // qtype + qclass
	localparam logic [15:0] QTAIL_PTR_LEN = 16'd5;   // pointer byte 2 + qtype + qclass
	localparam logic [15:0] AFIX_LEN      = 16'd10;  // type, class, ttl, rdlength
	localparam logic [15:0] ADDR_LEN      = 16'd4;
	localparam logic [15:0] TYPE_A        = 16'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] address;
	} out_t;

	typedef struct packed {
		logic [OFF_W-1:0] byte_offset;
		logic [3:0]       parse_phase;
		logic [15:0]      skip_count;
		logic [15:0]      questions_left;
		logic [15:0]      answers_left;
		logic [15:0]      header_word;
		logic [15:0]      record_type;
		logic [15:0]      record_length;
		logic [31:0]      address_acc;
		logic [2:0]       verdict;
	} state_t;

	localparam state_t STATE_CLEAR = '{
		byte_offset:    '0,
		parse_phase:    PH_HDR,
		skip_count:     '0,
		questions_left: '0,
		answers_left:   '0,
		header_word:    '0,
		record_type:    '0,
		record_length:  '0,
		address_acc:    '0,
		verdict:        V_UNDECIDED
	};

endpackage

// ----- rtl/core/dnsp_step.sv -----
// One-byte parser step: next message state and the result for a last byte.
// Depends on dnsp_pkg.
module dnsp_step (
	input  dnsp_pkg::state_t st,
	input  dnsp_pkg::in_t    item,
	input  logic [15:0]      expected_id,
	output dnsp_pkg::state_t st_next,
	output dnsp_pkg::out_t   result
);

	dnsp_pkg::state_t ns;
	logic [7:0]  b;
	logic [15:0] hw_new;
	logic [15:0] skip_dec;
	logic [15:0] ql_dec;
	logic [15:0] al_dec;
	logic [15:0] rt_new;
	logic [15:0] rl_new;
	logic [3:0]  fix_idx;
	logic [2:0]  status;

	assign b        = item.data_byte;
	assign hw_new   = st.byte_offset[0] ? {st.header_word[7:0], b} : {8'h00, b};
	assign skip_dec = st.skip_count - 16'd1;
	assign ql_dec   = st.questions_left - 16'd1;
	assign al_dec   = st.answers_left - 16'd1;
	assign fix_idx  = dnsp_pkg::AFIX_LEN[3:0] - st.skip_count[3:0];

	always_comb begin
		rt_new = st.record_type;
		rl_new = st.record_length;
		unique case (fix_idx)
			4'd0:    rt_new = {8'h00, b};
			4'd1:    rt_new = {st.record_type[7:0], b};
			4'd8:    rl_new = {8'h00, b};
			4'd9:    rl_new = {st.record_length[7:0], b};
			default: ;
		endcase
	end

	always_comb begin
		ns = st;
		if (st.byte_offset < dnsp_pkg::OFF_W'(dnsp_pkg::MAX_MSG)) begin
			ns.byte_offset = st.byte_offset + dnsp_pkg::OFF_W'(1);
			unique case (st.parse_phase)
				dnsp_pkg::PH_HDR: begin
					ns.header_word = hw_new;
					if (st.byte_offset == dnsp_pkg::OFF_W'(1) && hw_new != expected_id
					    && st.verdict == dnsp_pkg::V_UNDECIDED)
						ns.verdict = dnsp_pkg::ST_ID_MISM;
					if (st.byte_offset == dnsp_pkg::OFF_W'(3)
					    && st.verdict == dnsp_pkg::V_UNDECIDED) begin
						if ((hw_new & dnsp_pkg::HDR_QR_MASK) == 16'd0)
							ns.verdict = dnsp_pkg::ST_NOT_RESP;
						else if ((hw_new & dnsp_pkg::HDR_RCODE_MASK) != 16'd0)
							ns.verdict = dnsp_pkg::ST_RCODE;
					end
					if (st.byte_offset == dnsp_pkg::OFF_W'(5))
						ns.questions_left = hw_new;
					if (st.byte_offset == dnsp_pkg::OFF_W'(7))
						ns.answers_left = hw_new;
					if (st.byte_offset == dnsp_pkg::OFF_W'(dnsp_pkg::HDR_LEN - 1)) begin
						if (ns.verdict != dnsp_pkg::V_UNDECIDED)
							ns.parse_phase = dnsp_pkg::PH_DONE;
						else if (st.questions_left != 16'd0)
							ns.parse_phase = dnsp_pkg::PH_QLABEL;
						else if (st.answers_left == 16'd0) begin
							ns.verdict     = dnsp_pkg::ST_NO_A;
							ns.parse_phase = dnsp_pkg::PH_DONE;
						end else
							ns.parse_phase = dnsp_pkg::PH_ALABEL;
					end
				end
				dnsp_pkg::PH_QLABEL: begin
					if (b == 8'd0) begin
						ns.skip_count  = dnsp_pkg::QTAIL_LEN;
						ns.parse_phase = dnsp_pkg::PH_QTAIL;
					end else if ((b & dnsp_pkg::PTR_MARK) == dnsp_pkg::PTR_MARK) begin
						ns.skip_count  = dnsp_pkg::QTAIL_PTR_LEN;
						ns.parse_phase = dnsp_pkg::PH_QTAIL;
					end else begin
						ns.skip_count  = {8'h00, b};
						ns.parse_phase = dnsp_pkg::PH_QLABSKIP;
					end
				end
				dnsp_pkg::PH_QLABSKIP: begin
					ns.skip_count = skip_dec;
					if (skip_dec == 16'd0)
						ns.parse_phase = dnsp_pkg::PH_QLABEL;
				end
				dnsp_pkg::PH_QTAIL: begin
					ns.skip_count = skip_dec;
					if (skip_dec == 16'd0) begin
						ns.questions_left = ql_dec;
						if (ql_dec != 16'd0)
							ns.parse_phase = dnsp_pkg::PH_QLABEL;
						else if (st.answers_left == 16'd0) begin
							ns.verdict     = dnsp_pkg::ST_NO_A;
							ns.parse_phase = dnsp_pkg::PH_DONE;
						end else
							ns.parse_phase = dnsp_pkg::PH_ALABEL;
					end
				end
				dnsp_pkg::PH_ALABEL: begin
					if (b == 8'd0) begin
						ns.skip_count  = dnsp_pkg::AFIX_LEN;
						ns.parse_phase = dnsp_pkg::PH_AFIXED;
					end else if ((b & dnsp_pkg::PTR_MARK) == dnsp_pkg::PTR_MARK) begin
						ns.skip_count  = 16'd1;
						ns.parse_phase = dnsp_pkg::PH_APTR;
					end else begin
						ns.skip_count  = {8'h00, b};
						ns.parse_phase = dnsp_pkg::PH_ALABSKIP;
					end
				end
				dnsp_pkg::PH_ALABSKIP: begin
					ns.skip_count = skip_dec;
					if (skip_dec == 16'd0)
						ns.parse_phase = dnsp_pkg::PH_ALABEL;
				end
				dnsp_pkg::PH_APTR: begin
					ns.skip_count  = dnsp_pkg::AFIX_LEN;
					ns.parse_phase = dnsp_pkg::PH_AFIXED;
				end
				dnsp_pkg::PH_AFIXED: begin
					ns.record_type   = rt_new;
					ns.record_length = rl_new;
					ns.skip_count    = skip_dec;
					if (skip_dec == 16'd0) begin
						if (rt_new == dnsp_pkg::TYPE_A && rl_new == dnsp_pkg::ADDR_LEN) begin
							ns.skip_count  = dnsp_pkg::ADDR_LEN;
							ns.address_acc = '0;
							ns.parse_phase = dnsp_pkg::PH_AADDR;
						end else if (rl_new == 16'd0) begin
							ns.answers_left = al_dec;
							if (al_dec == 16'd0) begin
								ns.verdict     = dnsp_pkg::ST_NO_A;
								ns.parse_phase = dnsp_pkg::PH_DONE;
							end else
								ns.parse_phase = dnsp_pkg::PH_ALABEL;
						end else begin
							ns.skip_count  = rl_new;
							ns.parse_phase = dnsp_pkg::PH_ARDSKIP;
						end
					end
				end
				dnsp_pkg::PH_AADDR: begin
					ns.address_acc = {st.address_acc[23:0], b};
					ns.skip_count  = skip_dec;
					if (skip_dec == 16'd0) begin
						ns.verdict     = dnsp_pkg::ST_OK;
						ns.parse_phase = dnsp_pkg::PH_DONE;
					end
				end
				dnsp_pkg::PH_ARDSKIP: begin
					ns.skip_count = skip_dec;
					if (skip_dec == 16'd0) begin
						ns.answers_left = al_dec;
						if (al_dec == 16'd0) begin
							ns.verdict     = dnsp_pkg::ST_NO_A;
							ns.parse_phase = dnsp_pkg::PH_DONE;
						end else
							ns.parse_phase = dnsp_pkg::PH_ALABEL;
					end
				end
				default: ;
			endcase
		end
	end

	// status from the state after this byte
	always_comb begin
		priority if (ns.byte_offset < dnsp_pkg::OFF_W'(dnsp_pkg::HDR_LEN))
			status = dnsp_pkg::ST_SHORT;
		else if (ns.verdict != dnsp_pkg::V_UNDECIDED)
			status = ns.verdict;
		else if (ns.parse_phase == dnsp_pkg::PH_QLABEL
		         || ns.parse_phase == dnsp_pkg::PH_QLABSKIP
		         || ns.parse_phase == dnsp_pkg::PH_QTAIL)
			status = (ns.answers_left != 16'd0) ? dnsp_pkg::ST_TRUNC : dnsp_pkg::ST_NO_A;
		else
			status = dnsp_pkg::ST_TRUNC;
	end

	assign result.status  = status;
	assign result.address = (status == dnsp_pkg::ST_OK) ? ns.address_acc : 32'd0;
	assign st_next        = item.last_byte ? dnsp_pkg::STATE_CLEAR : ns;

endmodule

// ----- rtl/core/dnsp_out_reg.sv -----
// Result register for the parser's output channel; push only while empty or draining; not enforced here.
// Depends on dnsp_pkg.
module dnsp_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dnsp_pkg::out_t push_data,
	output logic           space,
	output logic           out_valid,
	input  logic           out_ready,
	output dnsp_pkg::out_t out_data
);

	logic           valid_q;
	dnsp_pkg::out_t data_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

endmodule

// ----- rtl/core/dns_response_a_record_parser.sv -----
// DNS response A-record parser: streaming byte parser, top level.
// Depends on dnsp_pkg, dnsp_step and dnsp_out_reg.
//
// Usage:
//  - in channel (in_valid/in_ready/in_data): one message byte per transfer,
//    last_byte marks the final byte of a DNS response. Bytes past MAX_MSG are
//    not parsed, but their last_byte flag still closes the message.
//  - out channel (out_valid/out_ready/out_data): one transfer per message,
//    carrying status and the IPv4 address (zero unless status is ok).
//  - cfg_wr_en/cfg_wr_data: writes expected_id; write only while idle.
// Timing:
//  - A byte lands in the input register, then the one-byte parser step
//    updates the message state register; for a last byte, the result is
//    pushed into the output register and offered on the out channel.
//  - Throughput is one byte per cycle, set by the per-byte state update
//    loop, but if the receiver stalls, the result waits in the output
//    register; bytes keep flowing until another last byte needs that
//    register, then in_ready drops until the result is taken.
// Reset: clears the message state, expected_id and both valid flags.
module dns_response_a_record_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dnsp_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output dnsp_pkg::out_t out_data,
	input  logic           cfg_wr_en,
	input  logic [15:0]    cfg_wr_data
);

	logic [15:0]      exp_id_q;
	logic             valid_s1;
	dnsp_pkg::in_t    item_s1;
	logic             adv_s1;
	logic             out_space;
	dnsp_pkg::state_t st_q;
	dnsp_pkg::state_t st_next;
	dnsp_pkg::out_t   step_result;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q <= '0;
		end else if (cfg_wr_en) begin
			exp_id_q <= cfg_wr_data;
		end
	end

	// staged byte advances unless it closes a message and the result slot is full
	assign adv_s1   = valid_s1 && (!item_s1.last_byte || out_space);
	assign in_ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	dnsp_step u_step (
		.st          (st_q),
		.item        (item_s1),
		.expected_id (exp_id_q),
		.st_next     (st_next),
		.result      (step_result)
	);

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dnsp_pkg::STATE_CLEAR;
		end else if (adv_s1) begin
			st_q <= st_next;
		end
	end

	dnsp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv_s1 && item_s1.last_byte),
		.push_data (step_result),
		.space     (out_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	// address is only reported for a successful lookup
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != dnsp_pkg::ST_OK |-> out_data.address == 32'd0)
		else $error("address nonzero on failed lookup");

	// offset saturates at the message limit
	a_off_sat: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.byte_offset <= dnsp_pkg::OFF_W'(dnsp_pkg::MAX_MSG))
		else $error("byte offset past limit");

	// closing byte restarts the message state
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.last_byte |=> st_q.byte_offset == '0
		&& st_q.parse_phase == dnsp_pkg::PH_HDR)
		else $error("message state not cleared after last byte");

	// a held byte waits unchanged for the result slot
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1))
		else $error("staged byte lost while stalled");

	// a result is only pushed when the slot is free
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.last_byte |-> !out_valid || out_ready)
		else $error("result overwritten");
`endif

endmodule
